// ===== rtl/daba_pkg.sv =====
// Shared types and constants of the dual converter burst averager.
package daba_pkg;

	localparam int BURST_LOG2 = 4;
	localparam int BURST_LEN  = 1 << BURST_LOG2;
	localparam int SAMPLE_W   = 16;
	localparam int SUM_W      = SAMPLE_W + BURST_LOG2;
	localparam int CNT_W      = BURST_LOG2 + 1;
	localparam int SEQ_W      = 32;

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

	localparam logic [2:0] ACT_START   = 3'd0;
	localparam logic [2:0] ACT_FRAME_A = 3'd1;
	localparam logic [2:0] ACT_FRAME_B = 3'd2;
	localparam logic [2:0] ACT_ERR_A   = 3'd3;
	localparam logic [2:0] ACT_ERR_B   = 3'd4;
	localparam logic [2:0] ACT_CHECK   = 3'd5;

	localparam logic [1:0] DONE_NONE = 2'b00;
	localparam logic [1:0] DONE_A    = 2'b01;
	localparam logic [1:0] DONE_B    = 2'b10;
	localparam logic [1:0] DONE_BOTH = 2'b11;

	typedef enum logic [2:0] {
		OP_START,
		OP_FRAME_A,
		OP_FRAME_B,
		OP_ERROR,
		OP_CHECK
	} op_t;

	typedef enum logic [1:0] {
		KIND_START  = 2'd0,
		KIND_RESULT = 2'd1,
		KIND_NOTIFY = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_VALID   = 2'd0,
		ST_DMA     = 2'd1,
		ST_FRAMING = 2'd2,
		ST_TIMING  = 2'd3
	} status_t;

	typedef enum logic {
		MODE_IDLE,
		MODE_RUNNING
	} mode_t;

	typedef struct packed {
		op_t                 op;
		logic [SAMPLE_W-1:0] sample;
		logic                frame_ok;
	} cmd_t;

	typedef struct packed {
		logic head_valid;
		logic full;
	} q_stat_t;

	typedef struct packed {
		logic notify_pend;
		logic running;
	} back_stat_t;

	typedef struct packed {
		kind_t                kind;
		status_t              status;
		logic [SAMPLE_W-1:0]  first_average;
		logic [SAMPLE_W-1:0]  second_average;
		logic [4:0]           samples_done;
		logic [1:0]           pair_mask;
		logic [SEQ_W-1:0]     result_sequence;
		logic                 last;
	} result_t;

endpackage

// ===== rtl/daba_if.sv =====
// Event and result channel interfaces of the burst averager.
interface daba_event_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] frame_byte0;
	logic [7:0] frame_byte1;
	logic [7:0] frame_byte2;

	modport source (output valid, action, frame_byte0, frame_byte1, frame_byte2, input ready);
	modport sink (input valid, action, frame_byte0, frame_byte1, frame_byte2, output ready);
endinterface

interface daba_result_if;
	import daba_pkg::*;
	logic          valid;
	logic          ready;
	kind_t         kind;
	status_t       status;
	logic [15:0]   first_average;
	logic [15:0]   second_average;
	logic [4:0]    samples_done;
	logic [1:0]    pair_mask;
	logic [31:0]   result_sequence;
	logic          last;

	modport source (output valid, kind, status, first_average, second_average, samples_done,
		pair_mask, result_sequence, last, input ready);
	modport sink (input valid, kind, status, first_average, second_average, samples_done,
		pair_mask, result_sequence, last, output ready);
endinterface

// ===== rtl/daba_front.sv =====
// Front end: accepts events, decodes the action and checks the frame bytes.
module daba_front (
	daba_event_if.sink       event_ch,
	input  daba_pkg::q_stat_t q_stat,
	output logic             push,
	output daba_pkg::cmd_t   cmd
);
	import daba_pkg::*;

	logic [SAMPLE_W-1:0] raw;
	logic [1:0]          tail;
	logic [1:0]          want;
	logic                known;

	always_comb begin
		raw = {event_ch.frame_byte0[1:0], event_ch.frame_byte1, event_ch.frame_byte2[7:2]};
		tail = event_ch.frame_byte2[1:0];
		want = {raw[1], raw[2]};
		cmd.sample = raw;
		cmd.frame_ok = !event_ch.frame_byte0[2] && (tail == want);
		cmd.op = OP_START;
		known = 1'b1;
		case (event_ch.action)
			ACT_START: begin
				cmd.op = OP_START;
			end
			ACT_FRAME_A: begin
				cmd.op = OP_FRAME_A;
			end
			ACT_FRAME_B: begin
				cmd.op = OP_FRAME_B;
			end
			ACT_ERR_A, ACT_ERR_B: begin
				cmd.op = OP_ERROR;
			end
			ACT_CHECK: begin
				cmd.op = OP_CHECK;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	assign event_ch.ready = !q_stat.full;
	// unused action codes are taken and dropped here
	assign push = event_ch.valid && event_ch.ready && known;

endmodule

// ===== rtl/daba_cmd_queue.sv =====
// Short command queue between the front end and the back end.
module daba_cmd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  daba_pkg::cmd_t    cmd_in,
	input  logic              pop,
	output daba_pkg::cmd_t    head,
	output daba_pkg::q_stat_t q_stat
);
	import daba_pkg::*;

	cmd_t                ent_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0]  wr_q;
	logic [CMDQ_AW-1:0]  rd_q;
	logic [CMDQ_CW-1:0]  cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + CMDQ_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + CMDQ_AW'(1);
			end
			case ({push, pop})
				2'b10: begin
					cnt_q <= cnt_q + CMDQ_CW'(1);
				end
				2'b01: begin
					cnt_q <= cnt_q - CMDQ_CW'(1);
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= cmd_in;
		end
	end

	assign head = ent_q[rd_q];
	assign q_stat.head_valid = (cnt_q != '0);
	assign q_stat.full = (cnt_q == CMDQ_CW'(CMDQ_DEPTH));

endmodule

// ===== rtl/daba_back.sv =====
// Back end: burst state, sums and result register.
module daba_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  daba_pkg::q_stat_t    q_stat,
	input  daba_pkg::cmd_t       head,
	output logic                 pop,
	daba_result_if.source        result_ch,
	output daba_pkg::back_stat_t stat
);
	import daba_pkg::*;

	typedef struct packed {
		logic    finish;
		status_t status;
		logic    use_avg;
		logic    begin_burst;
		logic    start_pair;
		logic    store;
		logic    acc;
		logic    notify;
	} decide_t;

	mode_t               mode_q, mode_n;
	logic                in_flight_q, in_flight_n;
	logic [1:0]          done_q, done_n;
	logic [CNT_W-1:0]    pair_cnt_q, pair_cnt_n;
	logic [SUM_W-1:0]    sum_a_q, sum_a_n;
	logic [SUM_W-1:0]    sum_b_q, sum_b_n;
	logic [SEQ_W-1:0]    pub_q, pub_n;
	logic                res_rdy_q, res_rdy_n;
	logic                pend_q, pend_n;
	logic                out_valid_q;
	result_t             out_q;
	logic [SAMPLE_W-1:0] smp_a_q, smp_b_q;
	logic                ok_a_q, ok_b_q;

	decide_t             d;
	logic                running;
	logic                active;
	logic [1:0]          done_new;
	logic [SAMPLE_W-1:0] smp_a_new, smp_b_new;
	logic                ok_a_new, ok_b_new;
	logic [SUM_W-1:0]    sum_a_acc, sum_b_acc;
	logic [CNT_W-1:0]    cnt_inc;
	logic [SEQ_W-1:0]    seq_next;
	logic                emits;
	logic                slot_free;
	logic                fire;
	logic                load;
	result_t             res;

	always_comb begin : decide
		running = (mode_q == MODE_RUNNING);
		active = running && in_flight_q;
		done_new = done_q | ((head.op == OP_FRAME_A) ? DONE_A : DONE_NONE)
			| ((head.op == OP_FRAME_B) ? DONE_B : DONE_NONE);
		smp_a_new = (head.op == OP_FRAME_A) ? head.sample : smp_a_q;
		smp_b_new = (head.op == OP_FRAME_B) ? head.sample : smp_b_q;
		ok_a_new = (head.op == OP_FRAME_A) ? head.frame_ok : ok_a_q;
		ok_b_new = (head.op == OP_FRAME_B) ? head.frame_ok : ok_b_q;
		sum_a_acc = sum_a_q + SUM_W'(smp_a_new);
		sum_b_acc = sum_b_q + SUM_W'(smp_b_new);
		cnt_inc = pair_cnt_q + CNT_W'(1);
		seq_next = pub_q + SEQ_W'(1);
		d = '0;
		d.status = ST_VALID;
		case (head.op)
			OP_START: begin
				if (running) begin
					d.finish = 1'b1;
					d.status = ST_TIMING;
				end else begin
					d.begin_burst = 1'b1;
					d.start_pair = 1'b1;
				end
			end
			OP_FRAME_A, OP_FRAME_B: begin
				if (active) begin
					d.store = 1'b1;
					if (done_new == DONE_BOTH) begin
						if (!(ok_a_new && ok_b_new)) begin
							d.finish = 1'b1;
							d.status = ST_FRAMING;
						end else begin
							d.acc = 1'b1;
							if (cnt_inc == CNT_W'(BURST_LEN)) begin
								d.finish = 1'b1;
								d.use_avg = 1'b1;
							end else begin
								d.start_pair = 1'b1;
							end
						end
					end
				end
			end
			OP_ERROR: begin
				if (active) begin
					d.finish = 1'b1;
					d.status = ST_DMA;
				end
			end
			OP_CHECK: begin
				d.notify = 1'b1;
				if (running || !res_rdy_q) begin
					d.finish = 1'b1;
					d.status = ST_TIMING;
				end
			end
			default: begin
			end
		endcase
		emits = d.finish || d.start_pair || d.notify;
		slot_free = !out_valid_q || result_ch.ready;
		fire = q_stat.head_valid && !pend_q && (slot_free || !emits);
	end

	assign pop = fire;

	always_comb begin : next_state
		mode_n = mode_q;
		in_flight_n = in_flight_q;
		done_n = done_q;
		pair_cnt_n = pair_cnt_q;
		sum_a_n = sum_a_q;
		sum_b_n = sum_b_q;
		pub_n = pub_q;
		res_rdy_n = res_rdy_q;
		pend_n = pend_q;
		if (fire) begin
			if (d.store) begin
				done_n = done_new;
			end
			if (d.begin_burst) begin
				mode_n = MODE_RUNNING;
				res_rdy_n = 1'b0;
				pair_cnt_n = '0;
				sum_a_n = '0;
				sum_b_n = '0;
			end
			if (d.acc) begin
				pair_cnt_n = cnt_inc;
				sum_a_n = sum_a_acc;
				sum_b_n = sum_b_acc;
			end
			if (d.start_pair) begin
				done_n = DONE_NONE;
				in_flight_n = 1'b1;
			end
			if (d.finish) begin
				done_n = DONE_NONE;
				in_flight_n = 1'b0;
				mode_n = MODE_IDLE;
				pub_n = seq_next;
				res_rdy_n = 1'b1;
			end
			if (d.finish && d.notify) begin
				pend_n = 1'b1;
			end
		end else if (pend_q && slot_free) begin
			pend_n = 1'b0;
		end
	end

	always_comb begin : outputs
		res = '0;
		load = 1'b0;
		if (pend_q) begin
			res.kind = KIND_NOTIFY;
			res.last = 1'b1;
			load = slot_free;
		end else if (fire && emits) begin
			load = 1'b1;
			if (d.finish) begin
				res.kind = KIND_RESULT;
				res.status = d.status;
				res.first_average = d.use_avg ? sum_a_acc[SUM_W-1:BURST_LOG2] : '0;
				res.second_average = d.use_avg ? sum_b_acc[SUM_W-1:BURST_LOG2] : '0;
				res.samples_done = d.acc ? 5'(cnt_inc) : 5'(pair_cnt_q);
				res.pair_mask = done_new;
				res.result_sequence = seq_next;
				res.last = !d.notify;
			end else if (d.start_pair) begin
				res.kind = KIND_START;
				res.last = 1'b1;
			end else begin
				res.kind = KIND_NOTIFY;
				res.last = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			in_flight_q <= 1'b0;
			done_q <= DONE_NONE;
			pair_cnt_q <= '0;
			sum_a_q <= '0;
			sum_b_q <= '0;
			pub_q <= '0;
			res_rdy_q <= 1'b0;
			pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mode_q <= mode_n;
			in_flight_q <= in_flight_n;
			done_q <= done_n;
			pair_cnt_q <= pair_cnt_n;
			sum_a_q <= sum_a_n;
			sum_b_q <= sum_b_n;
			pub_q <= pub_n;
			res_rdy_q <= res_rdy_n;
			pend_q <= pend_n;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// frame samples, meaningful only once written in the current pair
	always_ff @(posedge clk) begin
		if (fire && d.store && head.op == OP_FRAME_A) begin
			smp_a_q <= head.sample;
			ok_a_q <= head.frame_ok;
		end
		if (fire && d.store && head.op == OP_FRAME_B) begin
			smp_b_q <= head.sample;
			ok_b_q <= head.frame_ok;
		end
		if (load) begin
			out_q <= res;
		end
	end

	assign result_ch.valid = out_valid_q;
	assign result_ch.kind = out_q.kind;
	assign result_ch.status = out_q.status;
	assign result_ch.first_average = out_q.first_average;
	assign result_ch.second_average = out_q.second_average;
	assign result_ch.samples_done = out_q.samples_done;
	assign result_ch.pair_mask = out_q.pair_mask;
	assign result_ch.result_sequence = out_q.result_sequence;
	assign result_ch.last = out_q.last;

	assign stat.notify_pend = pend_q;
	assign stat.running = running;

endmodule

// ===== rtl/dual_adc_burst_averager.sv =====
// Dual converter burst averager top level.
// Usage:
//   event_ch carries one event item per handshake: start burst, frame done on
//   either converter (three received bytes), transfer error, or a check.
//   result_ch returns zero, one or two items per event: start conversion pair,
//   published result (status, averages, pair count, sequence) or notify; the
//   final item of an event has last set.
// The first result of an event passes through the command queue, written at the
//   accepting edge, and then the result register; a stalled result_ch can hold it.
// Throughput: one event per cycle while result_ch takes items; a check that
//   also publishes a timing error holds the back end until its notify is loaded.
// The front end decodes and checks frames and feeds a two-entry command
// queue; the back end drains it, so event_ch ready drops only when the queue
// is full.
// Reset clears the burst state, the queue pointers and the result valid flag; no
// burst is running and no result counts as published.
// A stalled result_ch holds its item; the back end stops, the queue fills,
// and then event_ch ready goes low.
module dual_adc_burst_averager (
	input logic           clk,
	input logic           arst_n,
	daba_event_if.sink    event_ch,
	daba_result_if.source result_ch
);
	import daba_pkg::*;

	cmd_t       push_cmd;
	cmd_t       head_cmd;
	logic       cmd_push;
	logic       cmd_pop;
	q_stat_t    q_stat;
	back_stat_t bk_stat;

	daba_front u_front (
		.event_ch (event_ch),
		.q_stat   (q_stat),
		.push     (cmd_push),
		.cmd      (push_cmd)
	);

	daba_cmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.cmd_in (push_cmd),
		.pop    (cmd_pop),
		.head   (head_cmd),
		.q_stat (q_stat)
	);

	daba_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head      (head_cmd),
		.pop       (cmd_pop),
		.result_ch (result_ch),
		.stat      (bk_stat)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> q_stat.head_valid)
		else $error("command popped from empty queue");

	a_pend_holds_queue: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.notify_pend |-> !cmd_pop)
		else $error("command taken while notify pending");

	a_start_while_running: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.kind == KIND_START |-> bk_stat.running)
		else $error("start pair shown while burst idle");

	a_notify_follows: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.ready && !result_ch.last
		|=> result_ch.valid && result_ch.kind == KIND_NOTIFY && result_ch.last)
		else $error("notify missing after non-final item");

endmodule

// ===== sim/tb.sv =====
// Testbench for the dual converter burst averager: directed events and random bursts checked by a scoreboard.
`timescale 1ns / 100ps

module tb;
	import daba_pkg::*;

	localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
	localparam logic [2:0] ACT_UNUSED_7 = 3'd7;
	localparam int IDLE_MAX    = 18;
	localparam int ITEM_TARGET = 1650;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_TAIL  = 16;

	class burst_average_tracker;
		mode_t              mode;
		bit                 in_flight;
		logic [1:0]         done_mask;
		logic [CNT_W-1:0]   pairs;
		logic [SUM_W-1:0]   sum_a;
		logic [SUM_W-1:0]   sum_b;
		logic [23:0]        frame_a;
		logic [23:0]        frame_b;
		logic [SEQ_W-1:0]   publish_cnt;
		bit                 have_result;
		result_t            pending_results[$];
		int                 errors;

		function new();
			mode        = MODE_IDLE;
			in_flight   = 1'b0;
			done_mask   = DONE_NONE;
			pairs       = '0;
			sum_a       = '0;
			sum_b       = '0;
			frame_a     = '0;
			frame_b     = '0;
			publish_cnt = '0;
			have_result = 1'b0;
			errors      = 0;
		endfunction

		// low framing bit must be clear, tail must repeat sample bits 1 and 2
		function automatic bit decode_frame(input logic [23:0] f, output logic [15:0] sample);
			logic [15:0] v;
			v = {f[17:16], f[15:8], f[7:2]};
			sample = v;
			return (f[18] == 1'b0) && (f[1:0] == {v[1], v[2]});
		endfunction

		function void push_plain(kind_t k);
			result_t r;
			r = '0;
			r.kind = k;
			pending_results.push_back(r);
		endfunction

		function void open_pair();
			done_mask = DONE_NONE;
			in_flight = 1'b1;
			push_plain(KIND_START);
		endfunction

		function void publish(status_t st, logic [15:0] avg_a, logic [15:0] avg_b);
			result_t r;
			r = '0;
			r.kind           = KIND_RESULT;
			r.status         = st;
			r.first_average  = avg_a;
			r.second_average = avg_b;
			r.samples_done   = pairs;
			r.pair_mask      = done_mask;
			in_flight   = 1'b0;
			done_mask   = DONE_NONE;
			mode        = MODE_IDLE;
			publish_cnt = publish_cnt + 1;
			have_result = 1'b1;
			r.result_sequence = publish_cnt;
			pending_results.push_back(r);
		endfunction

		function void accept_event(logic [2:0] act, logic [7:0] b0, logic [7:0] b1,
				logic [7:0] b2);
			int          n0;
			logic [15:0] s_a;
			logic [15:0] s_b;
			bit          ok_a;
			bit          ok_b;
			n0 = pending_results.size();
			case (act)
				ACT_START: begin
					if (mode != MODE_IDLE) begin
						publish(ST_TIMING, 16'h0, 16'h0);
					end else begin
						have_result = 1'b0;
						pairs = '0;
						sum_a = '0;
						sum_b = '0;
						mode  = MODE_RUNNING;
						open_pair();
					end
				end
				ACT_FRAME_A, ACT_FRAME_B: begin
					if (mode == MODE_RUNNING && in_flight) begin
						if (act == ACT_FRAME_A) begin
							frame_a = {b0, b1, b2};
							done_mask[0] = 1'b1;
						end else begin
							frame_b = {b0, b1, b2};
							done_mask[1] = 1'b1;
						end
						if (done_mask == DONE_BOTH) begin
							in_flight = 1'b0;
							ok_a = decode_frame(frame_a, s_a);
							ok_b = decode_frame(frame_b, s_b);
							if (!(ok_a && ok_b)) begin
								publish(ST_FRAMING, 16'h0, 16'h0);
							end else begin
								sum_a = sum_a + SUM_W'(s_a);
								sum_b = sum_b + SUM_W'(s_b);
								pairs = pairs + CNT_W'(1);
								if (pairs < BURST_LEN)
									open_pair();
								else
									publish(ST_VALID, 16'(sum_a >> BURST_LOG2),
										16'(sum_b >> BURST_LOG2));
							end
						end
					end
				end
				ACT_ERR_A, ACT_ERR_B: begin
					if (mode == MODE_RUNNING && in_flight)
						publish(ST_DMA, 16'h0, 16'h0);
				end
				ACT_CHECK: begin
					if (mode == MODE_RUNNING || !have_result)
						publish(ST_TIMING, 16'h0, 16'h0);
					push_plain(KIND_NOTIFY);
				end
				default: ;
			endcase
			if (pending_results.size() > n0)
				pending_results[pending_results.size() - 1].last = 1'b1;
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: kind %0h seq %0h", got.kind,
					got.result_sequence);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("kind", want.kind, got.kind);
			compare_field("status", want.status, got.status);
			compare_field("first_average", want.first_average, got.first_average);
			compare_field("second_average", want.second_average, got.second_average);
			compare_field("samples_done", want.samples_done, got.samples_done);
			compare_field("pair_mask", want.pair_mask, got.pair_mask);
			compare_field("result_sequence", want.result_sequence, got.result_sequence);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int unsigned cycle_cnt = 0;
	int sent = 0;
	bit src_idle = 1'b1;
	bit snk_idle = 1'b1;
	burst_average_tracker tracker = new();

	daba_event_if  ev();
	daba_result_if rs();

	dual_adc_burst_averager dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.event_ch (ev),
		.result_ch(rs)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [7:0] rb();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [15:0] pick_sample(int vmode);
		int r;
		if (vmode == 0)
			return 16'hFFFF;
		if (vmode == 1)
			return 16'h0000;
		r = $urandom_range(0, 7);
		if (r == 0)
			return 16'hFFFF;
		if (r == 1)
			return 16'h0000;
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic logic [23:0] make_frame(logic [15:0] v, bit bad_mark, bit bad_tail);
		logic [4:0] top;
		logic [1:0] tail;
		top  = 5'($urandom_range(0, 31));
		tail = {v[1], v[2]};
		if (bad_tail)
			tail = tail ^ 2'($urandom_range(1, 3));
		return {top, bad_mark, v[15:14], v[13:6], v[5:0], tail};
	endfunction

	task automatic send_event(logic [2:0] act, logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
		int gap;
		gap = src_idle ? $urandom_range(0, IDLE_MAX) : 0;
		if (gap > 0) begin
			ev.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ev.valid       <= 1'b1;
		ev.action      <= act;
		ev.frame_byte0 <= b0;
		ev.frame_byte1 <= b1;
		ev.frame_byte2 <= b2;
		do @(posedge clk); while (ev.ready !== 1'b1);
		tracker.accept_event(act, b0, b1, b2);
		sent++;
	endtask

	task automatic send_frame(logic [2:0] act, logic [23:0] f);
		send_event(act, f[23:16], f[15:8], f[7:0]);
	endtask

	task automatic drain();
		ev.valid <= 1'b0;
		do @(posedge clk); while (tracker.pending_results.size() != 0);
	endtask

	task automatic run_burst();
		int vmode;
		int fault_pair;
		int fault_kind;
		int fault_pos;
		bit a_first;
		logic [15:0] va;
		logic [15:0] vb;
		logic [23:0] fa;
		logic [23:0] fb;
		logic [2:0] first_act;
		logic [2:0] second_act;
		logic [2:0] fault_act;
		vmode      = $urandom_range(0, 9);
		fault_pair = ($urandom_range(0, 9) < 3) ? $urandom_range(0, BURST_LEN - 1) : BURST_LEN;
		fault_kind = $urandom_range(0, 5);
		fault_pos  = $urandom_range(0, 1);
		case (fault_kind)
			2: fault_act = ACT_ERR_A;
			3: fault_act = ACT_ERR_B;
			4: fault_act = ACT_CHECK;
			default: fault_act = ACT_START;
		endcase
		send_event(ACT_START, rb(), rb(), rb());
		for (int p = 0; p < BURST_LEN; p++) begin
			va = pick_sample(vmode);
			vb = pick_sample(vmode);
			fa = make_frame(va, p == fault_pair && fault_kind == 0, 1'b0);
			fb = make_frame(vb, 1'b0, p == fault_pair && fault_kind == 1);
			a_first    = $urandom_range(0, 1);
			first_act  = a_first ? ACT_FRAME_A : ACT_FRAME_B;
			second_act = a_first ? ACT_FRAME_B : ACT_FRAME_A;
			if ($urandom_range(0, 19) == 0)
				send_event($urandom_range(0, 1) ? ACT_UNUSED_6 : ACT_UNUSED_7, rb(), rb(), rb());
			if (p == fault_pair && fault_kind >= 2 && fault_pos == 0) begin
				send_event(fault_act, rb(), rb(), rb());
				return;
			end
			// a stale frame first, replaced by the real one
			if ($urandom_range(0, 15) == 0)
				send_event(first_act, rb(), rb(), rb());
			send_frame(first_act, a_first ? fa : fb);
			if (p == fault_pair && fault_kind >= 2) begin
				send_event(fault_act, rb(), rb(), rb());
				return;
			end
			send_frame(second_act, a_first ? fb : fa);
			if (p == fault_pair)
				return;
		end
	endtask

	initial begin
		result_t got;
		int stall;
		rs.ready <= 1'b0;
		do @(posedge clk); while (arst_n !== 1'b1);
		forever begin
			stall = snk_idle ? $urandom_range(0, IDLE_MAX) : 0;
			if (stall > 0) begin
				rs.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rs.ready <= 1'b1;
			do @(posedge clk); while (rs.valid !== 1'b1);
			got.kind            = rs.kind;
			got.status          = rs.status;
			got.first_average   = rs.first_average;
			got.second_average  = rs.second_average;
			got.samples_done    = rs.samples_done;
			got.pair_mask       = rs.pair_mask;
			got.result_sequence = rs.result_sequence;
			got.last            = rs.last;
			tracker.check_result(got);
		end
	end

	initial begin
		arst_n         <= 1'b0;
		ev.valid       <= 1'b0;
		ev.action      <= ACT_START;
		ev.frame_byte0 <= 8'h00;
		ev.frame_byte1 <= 8'h00;
		ev.frame_byte2 <= 8'h00;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send_event(ACT_CHECK, 8'h00, 8'h00, 8'h00);
		send_event(ACT_UNUSED_6, 8'hFF, 8'hFF, 8'hFF);
		send_event(ACT_UNUSED_7, 8'h00, 8'h00, 8'h00);
		send_frame(ACT_FRAME_A, make_frame(16'h1234, 1'b0, 1'b0));
		send_event(ACT_ERR_B, 8'hFF, 8'h00, 8'hFF);
		send_event(ACT_START, 8'h00, 8'h00, 8'h00);
		send_frame(ACT_FRAME_A, make_frame(16'hFFFF, 1'b1, 1'b0));
		send_frame(ACT_FRAME_A, make_frame(16'hFFFF, 1'b0, 1'b0));
		send_frame(ACT_FRAME_B, make_frame(16'h0000, 1'b0, 1'b0));
		send_event(ACT_CHECK, 8'h00, 8'h00, 8'h00);
		send_event(ACT_CHECK, 8'hFF, 8'hFF, 8'hFF);
		send_event(ACT_START, 8'h00, 8'h00, 8'h00);
		send_event(ACT_ERR_A, 8'h00, 8'h00, 8'h00);
		send_event(ACT_START, 8'h00, 8'h00, 8'h00);
		send_frame(ACT_FRAME_B, make_frame(16'hA5A5, 1'b0, 1'b0));
		send_event(ACT_ERR_B, 8'h00, 8'h00, 8'h00);
		send_event(ACT_START, 8'h00, 8'h00, 8'h00);
		send_event(ACT_START, 8'h00, 8'h00, 8'h00);
		send_event(ACT_START, 8'h00, 8'h00, 8'h00);
		send_frame(ACT_FRAME_A, make_frame(16'h5A5A, 1'b0, 1'b0));
		send_frame(ACT_FRAME_B, make_frame(16'h0F0F, 1'b0, 1'b1));
		send_event(ACT_START, 8'h00, 8'h00, 8'h00);
		send_frame(ACT_FRAME_B, make_frame(16'hFFFF, 1'b1, 1'b0));
		send_frame(ACT_FRAME_A, make_frame(16'h0001, 1'b0, 1'b0));
		drain();

		// random
		while (sent < ITEM_TARGET) begin
			src_idle = $urandom_range(0, 3) != 0;
			snk_idle = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 6) != 0) begin
				run_burst();
				if ($urandom_range(0, 2) == 0)
					send_event(ACT_CHECK, rb(), rb(), rb());
				if ($urandom_range(0, 5) == 0)
					send_event($urandom_range(0, 1) ? ACT_FRAME_A : ACT_FRAME_B, rb(), rb(), rb());
			end else begin
				repeat ($urandom_range(1, 5))
					send_event(3'($urandom_range(0, 7)), rb(), rb(), rb());
			end
			if ($urandom_range(0, 7) == 0)
				drain();
		end

		drain();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/daba_pkg.sv
rtl/daba_if.sv
rtl/daba_front.sv
rtl/daba_cmd_queue.sv
rtl/daba_back.sv
rtl/dual_adc_burst_averager.sv
sim/tb.sv
